// File: src/gfac_pkg.sv
// Shared types, constants and a helper function for the gas and flame alarm conditioner.
`default_nettype none
package gfac_pkg;

  localparam int SampleBits    = 12;
  localparam int TickBits      = 16;
  localparam int SumBits       = SampleBits + TickBits;
  localparam int DebounceCount = 3;
  localparam int CntBits       = $clog2(DebounceCount + 1);
  localparam int DivSteps      = SumBits;
  localparam int DivCntBits    = $clog2(DivSteps);

  localparam logic [TickBits-1:0] TickMax = {TickBits{1'b1}};

  // configuration port
  localparam int CfgIdxBits  = 2;
  localparam int CfgDataBits = 16;
  localparam logic [CfgIdxBits-1:0] CfgWarmup  = 2'd0;
  localparam logic [CfgIdxBits-1:0] CfgOffset  = 2'd1;
  localparam logic [CfgIdxBits-1:0] CfgFlameTh = 2'd2;

  localparam logic [TickBits-1:0]   WarmupReset  = 16'd3000;
  localparam logic [SampleBits-1:0] OffsetReset  = 12'd500;
  localparam logic [SampleBits-1:0] FlameThReset = 12'd2000;

  typedef struct packed {
    logic [11:0] smoke_sample;
    logic [11:0] flame_sample;
  } in_t;

  typedef struct packed {
    logic [11:0] smoke_level;
    logic [11:0] smoke_baseline;
    logic [11:0] smoke_delta;
    logic        smoke_ready;
    logic        smoke_alarm;
    logic        flame_alarm;
  } out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TICK,
    ST_DIV,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic [CntBits-1:0] cnt;
    logic               flag;
  } deb_t;

  // up/down debounce: rise on a hit (stop at the count), fall on a miss, clear flag at zero
  function automatic deb_t debounce(input logic hit, input deb_t cur);
    deb_t r;
    r = cur;
    if (hit) begin
      if (cur.cnt < CntBits'(DebounceCount)) r.cnt = cur.cnt + 1'b1;
      if (r.cnt >= CntBits'(DebounceCount)) r.flag = 1'b1;
    end else begin
      if (cur.cnt != '0) r.cnt = cur.cnt - 1'b1;
      else r.flag = 1'b0;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: src/gfac_in_if.sv
// Valid/ready channel carrying one sample tick.
`default_nettype none
interface gfac_in_if;
  logic         valid;
  logic         ready;
  gfac_pkg::in_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// File: src/gfac_out_if.sv
// Valid/ready channel carrying one conditioned result.
`default_nettype none
interface gfac_out_if;
  logic          valid;
  logic          ready;
  gfac_pkg::out_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// File: src/gas_flame_alarm_conditioner_top.sv
// Top level of the gas and flame alarm conditioner: sequencer, serial divider and debounce.
`default_nettype none
// One transfer on sample_i is one sample tick and yields exactly one transfer on result_o.
// A tick normally passes through the accept, tick update and judge steps before the next
// transfer in; its result is loaded into the output register at the end of the judge step.
// The one tick that ends warm-up, if smoke samples were taken, also computes the
// clean-air baseline as sum / count on a restore-and-subtract divider that produces one
// quotient bit a cycle, in a divide step between tick update and judge. The output
// register holds a finished result while the next tick is already being transferred in;
// the judge step waits only if the previous result has still not been taken. The tick
// counter saturates at 65535. Write the configuration registers (warm-up length, smoke
// offset, flame threshold) only while no tick is in flight; writes to an unused index
// are ignored.
module gas_flame_alarm_conditioner_top (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [gfac_pkg::CfgIdxBits-1:0]  cfg_idx_i,
  input  wire logic [gfac_pkg::CfgDataBits-1:0] cfg_wdata_i,
  gfac_in_if.sink                               sample_i,
  gfac_out_if.source                            result_o
);

  // configuration
  logic [gfac_pkg::TickBits-1:0]   warmup_q;
  logic [gfac_pkg::SampleBits-1:0] offset_q;
  logic [gfac_pkg::SampleBits-1:0] flame_th_q;

  // sequencer
  gfac_pkg::state_e state_q, state_d;
  logic [gfac_pkg::DivCntBits-1:0] div_cnt_q;

  // held sample of the current tick
  logic [gfac_pkg::SampleBits-1:0] smoke_q;
  logic [gfac_pkg::SampleBits-1:0] flame_q;

  // conditioning state
  logic [gfac_pkg::TickBits-1:0]   elapsed_q;
  logic [gfac_pkg::SumBits-1:0]    sum_q;
  logic [gfac_pkg::TickBits-1:0]   count_q;
  logic [gfac_pkg::SampleBits-1:0] baseline_q;
  logic                            calib_done_q;
  logic                            ready_flag_q;
  logic                            warm_q;
  gfac_pkg::deb_t                  smoke_deb_q;
  gfac_pkg::deb_t                  flame_deb_q;

  // divider: remainder and dividend/quotient shift register
  logic [gfac_pkg::TickBits-1:0] rem_q;
  logic [gfac_pkg::SumBits-1:0]  quo_q;

  // output register
  logic           out_valid_q;
  gfac_pkg::out_t out_q;

  // ---------------------------------------------------------------- combinational
  logic [gfac_pkg::TickBits-1:0]   tick_inc;
  logic                            warm_now;
  logic                            start_div;
  logic [gfac_pkg::TickBits:0]     div_trial;
  logic                            div_ge;
  logic [gfac_pkg::SampleBits-1:0] delta;
  logic                            out_free;
  gfac_pkg::deb_t                  smoke_deb_d;
  gfac_pkg::deb_t                  flame_deb_d;

  // saturating tick count and warm-up decision for this tick
  assign tick_inc  = (elapsed_q != gfac_pkg::TickMax) ? elapsed_q + 1'b1 : elapsed_q;
  assign warm_now  = tick_inc >= warmup_q;
  assign start_div = warm_now && !calib_done_q && (count_q != '0);

  // one restoring step: shift in the next dividend bit, subtract the count if it fits
  assign div_trial = {rem_q, quo_q[gfac_pkg::SumBits-1]};
  assign div_ge    = div_trial >= {1'b0, count_q};

  assign delta = ((baseline_q != '0) && (smoke_q > baseline_q)) ? smoke_q - baseline_q : '0;

  always_comb begin
    smoke_deb_d = gfac_pkg::debounce(delta >= offset_q, smoke_deb_q);
    if (!warm_q) begin
      smoke_deb_d = '0;  // hold the smoke counter and alarm low during warm-up
    end
    flame_deb_d = gfac_pkg::debounce(flame_q < flame_th_q, flame_deb_q);
  end

  assign out_free = !out_valid_q || result_o.ready;

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gfac_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      gfac_pkg::ST_IDLE: begin
        if (sample_i.valid) state_d = gfac_pkg::ST_TICK;
      end
      gfac_pkg::ST_TICK: begin
        state_d = start_div ? gfac_pkg::ST_DIV : gfac_pkg::ST_FIN;
      end
      gfac_pkg::ST_DIV: begin
        if (div_cnt_q == gfac_pkg::DivCntBits'(gfac_pkg::DivSteps - 1)) begin
          state_d = gfac_pkg::ST_FIN;
        end
      end
      gfac_pkg::ST_FIN: begin
        if (out_free) state_d = gfac_pkg::ST_IDLE;
      end
      default: state_d = gfac_pkg::ST_IDLE;
    endcase
  end

  assign sample_i.ready = (state_q == gfac_pkg::ST_IDLE);

  // ---------------------------------------------------------------- configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      warmup_q   <= gfac_pkg::WarmupReset;
      offset_q   <= gfac_pkg::OffsetReset;
      flame_th_q <= gfac_pkg::FlameThReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        gfac_pkg::CfgWarmup:  warmup_q   <= cfg_wdata_i[gfac_pkg::TickBits-1:0];
        gfac_pkg::CfgOffset:  offset_q   <= cfg_wdata_i[gfac_pkg::SampleBits-1:0];
        gfac_pkg::CfgFlameTh: flame_th_q <= cfg_wdata_i[gfac_pkg::SampleBits-1:0];
        default: ;  // unused index: drop the write
      endcase
    end
  end

  // ---------------------------------------------------------------- sample latch
  always_ff @(posedge clk_i) begin
    if (sample_i.valid && sample_i.ready) begin
      smoke_q <= sample_i.payload.smoke_sample;
      flame_q <= sample_i.payload.flame_sample;
    end
  end

  // ---------------------------------------------------------------- conditioning state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elapsed_q    <= '0;
      sum_q        <= '0;
      count_q      <= '0;
      baseline_q   <= '0;
      calib_done_q <= 1'b0;
      ready_flag_q <= 1'b0;
      warm_q       <= 1'b0;
      smoke_deb_q  <= '0;
      flame_deb_q  <= '0;
      div_cnt_q    <= '0;
    end else begin
      unique case (state_q)
        gfac_pkg::ST_TICK: begin
          elapsed_q <= tick_inc;
          warm_q    <= warm_now;
          div_cnt_q <= '0;
          if (!warm_now) begin
            // accumulate the calibration sum; it wraps at its width
            sum_q <= sum_q + gfac_pkg::SumBits'(smoke_q);
            if (count_q != gfac_pkg::TickMax) count_q <= count_q + 1'b1;
          end else begin
            ready_flag_q <= 1'b1;
            calib_done_q <= 1'b1;
          end
        end
        gfac_pkg::ST_DIV: begin
          div_cnt_q <= div_cnt_q + 1'b1;
          if (div_cnt_q == gfac_pkg::DivCntBits'(gfac_pkg::DivSteps - 1)) begin
            // last quotient bit lands now; keep the low bits only
            baseline_q <= {quo_q[gfac_pkg::SampleBits-2:0], div_ge};
          end
        end
        gfac_pkg::ST_FIN: begin
          if (out_free) begin
            smoke_deb_q <= smoke_deb_d;
            flame_deb_q <= flame_deb_d;
          end
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- divider datapath
  always_ff @(posedge clk_i) begin
    if (state_q == gfac_pkg::ST_TICK) begin
      rem_q <= '0;
      quo_q <= sum_q;
    end else if (state_q == gfac_pkg::ST_DIV) begin
      rem_q <= div_ge ? gfac_pkg::TickBits'(div_trial - {1'b0, count_q})
                      : div_trial[gfac_pkg::TickBits-1:0];
      quo_q <= {quo_q[gfac_pkg::SumBits-2:0], div_ge};
    end
  end

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == gfac_pkg::ST_FIN) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == gfac_pkg::ST_FIN) && out_free) begin
      out_q.smoke_level    <= smoke_q;
      out_q.smoke_baseline <= baseline_q;
      out_q.smoke_delta    <= delta;
      out_q.smoke_ready    <= ready_flag_q;
      out_q.smoke_alarm    <= smoke_deb_d.flag;
      out_q.flame_alarm    <= flame_deb_d.flag;
    end
  end

  assign result_o.valid   = out_valid_q;
  assign result_o.payload = out_q;

  // ---------------------------------------------------------------- assertions
  // A transfer in starts a tick: the block is busy the cycle after.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sample_i.valid && sample_i.ready) |=> !sample_i.ready)
    else $error("sample accepted while a tick was still in flight");

  // The baseline is fixed once calibration is done, except as the divider finishes.
  a_baseline_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (calib_done_q && (state_q != gfac_pkg::ST_DIV)) |=> $stable(baseline_q))
    else $error("baseline changed after calibration");

  // A new result is loaded only from the judge step.
  a_result_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == gfac_pkg::ST_FIN))
    else $error("result raised outside the judge step");

  // Smoke debounce counter stays within its range.
  a_smoke_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    smoke_deb_q.cnt <= gfac_pkg::CntBits'(gfac_pkg::DebounceCount))
    else $error("smoke debounce counter out of range");

endmodule
`default_nettype wire

// File: dv/gfac_tb_pkg.sv
// Scoreboard for the gas and flame alarm conditioner: tick predictor and result checker.
package gfac_tb_pkg;
  import gfac_pkg::*;

  class alarm_conditioner_model;
    // configuration copy
    logic [TickBits-1:0]   warmup_len;
    logic [SampleBits-1:0] offset;
    logic [SampleBits-1:0] flame_th;
    // conditioner state
    logic [TickBits-1:0]   ticks;
    logic [SumBits-1:0]    smoke_sum;
    logic [TickBits-1:0]   sample_count;
    logic [SampleBits-1:0] baseline;
    bit                    calibrated;
    bit                    judging;
    logic [CntBits-1:0]    smoke_cnt;
    logic [CntBits-1:0]    flame_cnt;
    bit                    smoke_flag;
    bit                    flame_flag;

    out_t expected_results[$];
    int   errors;
    int   checked;
    int   reg_writes;
    int   judged_ticks;
    int   smoke_alarm_ticks;
    int   flame_alarm_ticks;

    function new();
      warmup_len        = WarmupReset;
      offset            = OffsetReset;
      flame_th          = FlameThReset;
      ticks             = '0;
      smoke_sum         = '0;
      sample_count      = '0;
      baseline          = '0;
      calibrated        = 1'b0;
      judging           = 1'b0;
      smoke_cnt         = '0;
      flame_cnt         = '0;
      smoke_flag        = 1'b0;
      flame_flag        = 1'b0;
      errors            = 0;
      checked           = 0;
      reg_writes        = 0;
      judged_ticks      = 0;
      smoke_alarm_ticks = 0;
      flame_alarm_ticks = 0;
    endfunction

    function void write_reg(logic [CfgIdxBits-1:0] idx, logic [CfgDataBits-1:0] val);
      reg_writes++;
      case (idx)
        CfgWarmup:  warmup_len = val[TickBits-1:0];
        CfgOffset:  offset     = val[SampleBits-1:0];
        CfgFlameTh: flame_th   = val[SampleBits-1:0];
        default: ;
      endcase
    endfunction

    // up/down counter: climb to the debounce count on hits, sink on misses, drop flag at zero
    function void debounce_step(input bit hit, inout logic [CntBits-1:0] cnt, inout bit flag);
      if (hit) begin
        if (cnt < CntBits'(DebounceCount)) cnt = cnt + 1'b1;
        if (cnt >= CntBits'(DebounceCount)) flag = 1'b1;
      end else if (cnt != '0) begin
        cnt = cnt - 1'b1;
      end else begin
        flag = 1'b0;
      end
    endfunction

    function void note_tick(in_t t);
      out_t                  r;
      logic [SampleBits-1:0] delta;
      bit                    warm;
      delta = '0;
      if (ticks != TickMax) ticks = ticks + 1'b1;
      warm = (ticks >= warmup_len);
      if (!warm) begin
        smoke_sum = smoke_sum + SumBits'(t.smoke_sample);
        if (sample_count != TickMax) sample_count = sample_count + 1'b1;
      end
      if (warm && !calibrated) begin
        calibrated = 1'b1;
        if (sample_count != '0) baseline = SampleBits'(smoke_sum / SumBits'(sample_count));
      end
      if (baseline != '0 && t.smoke_sample > baseline) delta = t.smoke_sample - baseline;
      if (warm) begin
        judging = 1'b1;
        judged_ticks++;
        debounce_step(delta >= offset, smoke_cnt, smoke_flag);
      end else begin
        smoke_cnt  = '0;
        smoke_flag = 1'b0;
      end
      debounce_step(t.flame_sample < flame_th, flame_cnt, flame_flag);
      r.smoke_level    = t.smoke_sample;
      r.smoke_baseline = baseline;
      r.smoke_delta    = delta;
      r.smoke_ready    = judging;
      r.smoke_alarm    = smoke_flag;
      r.flame_alarm    = flame_flag;
      expected_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [11:0] want, logic [11:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (expected_results.size() == 0) begin
        $error("result transfer with no tick outstanding");
        errors++;
        return;
      end
      want = expected_results.pop_front();
      checked++;
      if (want.smoke_alarm) smoke_alarm_ticks++;
      if (want.flame_alarm) flame_alarm_ticks++;
      compare_field("smoke_level", want.smoke_level, got.smoke_level);
      compare_field("smoke_baseline", want.smoke_baseline, got.smoke_baseline);
      compare_field("smoke_delta", want.smoke_delta, got.smoke_delta);
      compare_field("smoke_ready", 12'(want.smoke_ready), 12'(got.smoke_ready));
      compare_field("smoke_alarm", 12'(want.smoke_alarm), 12'(got.smoke_alarm));
      compare_field("flame_alarm", 12'(want.flame_alarm), 12'(got.flame_alarm));
    endfunction

    function void close_out();
      if (expected_results.size() != 0) begin
        $error("%0d expected results never arrived", expected_results.size());
        errors++;
      end
    endfunction
  endclass

endpackage

// File: dv/tb_top.sv
// Testbench top: drives sample ticks and register writes, checks every conditioned result.
module tb_top;
  import gfac_pkg::*;
  import gfac_tb_pkg::*;

  // index with no register behind it; writes to it must change nothing
  localparam logic [CfgIdxBits-1:0] CfgUnused = 2'd3;

  localparam int SettleCycles   = 8;
  localparam int TailCycles     = 40;
  localparam int LongHoldCycles = 400;
  localparam int TimeoutUnits   = 2_000_000;

  typedef enum int {ShapeCalib, ShapeJudge, ShapeNoise} shape_e;
  typedef enum int {StallNone, StallHalf, StallQuarter, StallRare} stall_e;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we;
  logic [CfgIdxBits-1:0]  cfg_idx;
  logic [CfgDataBits-1:0] cfg_wdata;

  gfac_in_if  sample_if ();
  gfac_out_if result_if ();

  gas_flame_alarm_conditioner_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .sample_i    (sample_if.sink),
    .result_o    (result_if.source)
  );

  alarm_conditioner_model cond_model;

  // written by the stimulus process only; the result sink merely reads them
  bit quick_mode;
  bit hold_armed;

  // stimulus generator state: alternating runs of hits and misses per sensor
  bit                    offering;
  bit                    smoke_hit;
  bit                    flame_hit;
  int                    smoke_run_left;
  int                    flame_run_left;
  int                    burst_left;
  logic [SampleBits-1:0] calib_level;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop: several times the slowest correct run.
  initial begin
    #(TimeoutUnits);
    $display("tb_top failed");
    $finish;
  end

  function automatic in_t tick_of(logic [11:0] smoke, logic [11:0] flame);
    in_t t;
    t.smoke_sample = smoke;
    t.flame_sample = flame;
    return t;
  endfunction

  // Offer one tick and hold it until the transfer; leave valid high for a following tick.
  task automatic send_tick(input in_t t);
    sample_if.valid   <= 1'b1;
    sample_if.payload <= t;
    offering = 1'b1;
    @(posedge clk_i);
    while (!sample_if.ready) @(posedge clk_i);
    cond_model.note_tick(t);
  endtask

  // Drop valid and wait for every outstanding result, then let the block settle.
  task automatic drain_results();
    if (offering) begin
      sample_if.valid <= 1'b0;
      offering = 1'b0;
    end
    while (cond_model.expected_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // One register write; the enable is lowered in the cycle after it is raised, so back-to-back writes
  // never lower and raise it within the same step.
  task automatic write_reg(input logic [CfgIdxBits-1:0] idx, input logic [CfgDataBits-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    cond_model.write_reg(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  // Random ticks shaped for the phase at hand, paced in bursts with random gaps.
  task automatic run_ticks(input int n, input shape_e shape);
    in_t t;
    int  lo;
    int  th;
    int  v;
    int  gap;
    for (int i = 0; i < n; i++) begin
      if (smoke_run_left == 0) begin
        smoke_hit      = !smoke_hit;
        smoke_run_left = $urandom_range(1, 6);
      end
      if (flame_run_left == 0) begin
        flame_hit      = !flame_hit;
        flame_run_left = $urandom_range(1, 6);
      end
      smoke_run_left--;
      flame_run_left--;

      if (shape == ShapeNoise || $urandom_range(0, 9) == 0) begin
        // noise: ignore the run structure altogether
        t.smoke_sample = 12'($urandom_range(0, 4095));
        t.flame_sample = 12'($urandom_range(0, 4095));
      end else begin
        // flame: land either side of the threshold, often right on its edge
        th = int'(cond_model.flame_th);
        if (flame_hit && th > 0)
          t.flame_sample = ($urandom_range(0, 3) == 0) ? 12'(th - 1)
                                                         : 12'($urandom_range(0, th - 1));
        else if (!flame_hit)
          t.flame_sample = ($urandom_range(0, 3) == 0) ? 12'(th)
                                                         : 12'($urandom_range(th, 4095));
        else
          t.flame_sample = 12'($urandom_range(0, 4095));

        if (shape == ShapeCalib) begin
          // clean air: scatter around the level picked for this run
          v = int'(calib_level) + int'($urandom_range(0, 600)) - 300;
          if (v < 0) v = 0;
          if (v > 4095) v = 4095;
          t.smoke_sample = 12'(v);
        end else begin
          // judging: hit means the delta over the baseline reaches the offset
          lo = int'(cond_model.baseline) + int'(cond_model.offset);
          if (cond_model.baseline == '0 || cond_model.offset == '0 || lo > 4095)
            t.smoke_sample = 12'($urandom_range(0, 4095));
          else if (smoke_hit)
            t.smoke_sample = ($urandom_range(0, 3) == 0) ? 12'(lo)
                                                           : 12'($urandom_range(lo, 4095));
          else
            t.smoke_sample = ($urandom_range(0, 3) == 0) ? 12'(lo - 1)
                                                           : 12'($urandom_range(0, lo - 1));
        end
      end

      send_tick(t);

      // pace: long bursts give stretches with no idling at all
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        if (quick_mode) gap = ($urandom_range(0, 49) == 0) ? 1 : 0;
        else gap = int'($urandom_range(1, 8));
        burst_left = ($urandom_range(0, 3) == 0) ? int'($urandom_range(40, 120))
                                                  : int'($urandom_range(1, 20));
        if (gap > 0) begin
          sample_if.valid <= 1'b0;
          offering = 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
    end
  endtask

  // Result sink: check each transfer, stall on a pattern of its own, and hold off once
  // for a long stretch so the block fills up and stalls its input.
  initial begin : result_sink
    stall_e mode;
    int     mode_left;
    int     hold_left;
    bit     hold_done;
    bit     take;
    mode      = StallNone;
    mode_left = 0;
    hold_left = 0;
    hold_done = 1'b0;
    result_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && result_if.valid && result_if.ready)
        cond_model.check_result(result_if.payload);
      if (hold_armed && !hold_done) begin
        hold_done = 1'b1;
        hold_left = LongHoldCycles;
      end
      if (mode_left == 0) begin
        mode      = stall_e'($urandom_range(0, 3));
        mode_left = $urandom_range(5, 60);
      end
      mode_left--;
      if (hold_left > 0) begin
        take = 1'b0;
        hold_left--;
      end else if (quick_mode) begin
        take = 1'b1;
      end else begin
        case (mode)
          StallNone:    take = 1'b1;
          StallHalf:    take = 1'($urandom_range(0, 1));
          StallQuarter: take = (mode_left % 4 == 0);
          default:      take = ($urandom_range(0, 7) != 0);
        endcase
      end
      result_if.ready <= take;
    end
  end

  initial begin : stimulus
    bit                    empty_calib;
    int                    chunk;
    int                    target;
    logic [SampleBits-1:0] v;
    logic [SampleBits-1:0] w;

    // drive every input to a known value from the start
    rst_ni            <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_idx           <= CfgWarmup;
    cfg_wdata         <= '0;
    sample_if.valid   <= 1'b0;
    sample_if.payload <= '0;
    quick_mode     = 1'b0;
    hold_armed     = 1'b0;
    offering       = 1'b0;
    smoke_hit      = 1'b0;
    flame_hit      = 1'b0;
    smoke_run_left = 0;
    flame_run_left = 0;
    burst_left     = 0;
    cond_model     = new();

    // The baseline is computed once per run, so the empty warm-up (no samples, baseline
    // held at zero) is taken by a minority of seeds; the rest calibrate on real samples.
    empty_calib = ($urandom_range(0, 9) == 0);
    calib_level = 12'($urandom_range(0, 4095));

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // keep the warm-up short so the judging phases get most of the ticks
    if (empty_calib) write_reg(CfgWarmup, 16'd0);
    else write_reg(CfgWarmup, 16'($urandom_range(150, 300)));

    // Directed: field extremes and alternating bit patterns; flame debounce up to set,
    // down to clear, around the reset threshold, then at the threshold extremes.
    send_tick(tick_of(12'd0,    12'd0));
    send_tick(tick_of(12'd4095, 12'd0));
    send_tick(tick_of(12'hAAA,  12'd1999));
    send_tick(tick_of(12'h555,  12'd4095));
    send_tick(tick_of(12'd0,    12'd2000));
    send_tick(tick_of(12'd4095, 12'd2001));
    send_tick(tick_of(12'd1,    12'd4095));
    send_tick(tick_of(12'd4094, 12'd1999));
    send_tick(tick_of(12'd2048, 12'd1998));
    send_tick(tick_of(12'd2047, 12'h555));
    send_tick(tick_of(12'd0,    12'd0));
    send_tick(tick_of(12'd4095, 12'd0));
    drain_results();
    // threshold zero: no flame reading can be a hit
    write_reg(CfgFlameTh, 16'h0000);
    repeat (4) send_tick(tick_of(12'h555, 12'd0));
    drain_results();
    // threshold at full scale with junk in the upper data bits
    write_reg(CfgFlameTh, 16'hFFFF);
    send_tick(tick_of(12'hFFF, 12'd4094));
    send_tick(tick_of(12'd0,   12'd4095));
    repeat (3) send_tick(tick_of(12'hAAA, 12'd4094));
    drain_results();
    write_reg(CfgUnused, 16'hFFFF);
    send_tick(tick_of(12'h5A5, 12'hA5A));
    drain_results();

    // Warm-up: feed clean-air readings until calibration and a little beyond,
    // moving the flame threshold between chunks.
    chunk = 0;
    while (int'(cond_model.ticks) < int'(cond_model.warmup_len) + 40) begin
      if (chunk == 1) v = 12'd0;
      else if (chunk == 2) v = 12'd4095;
      else v = 12'($urandom_range(0, 4095));
      write_reg(CfgFlameTh, {4'($urandom_range(0, 15)), v});
      target = int'(cond_model.warmup_len) + 40 - int'(cond_model.ticks);
      run_ticks((target > 100) ? 100 : target, ShapeCalib);
      drain_results();
      chunk++;
    end

    // Judging: a spread of offsets and flame thresholds, extremes first.
    for (int k = 0; k < 8; k++) begin
      case (k)
        0:       v = 12'd0;
        1:       v = 12'd4095;
        2:       v = 12'($urandom_range(1, 150));
        3:       v = 12'($urandom_range(0, 4095));
        default: v = 12'($urandom_range(1, 800));
      endcase
      case (k)
        1:       w = 12'd4095;
        2:       w = 12'd0;
        default: w = 12'($urandom_range(0, 4095));
      endcase
      write_reg(CfgOffset, {4'($urandom_range(0, 15)), v});
      write_reg(CfgFlameTh, {4'($urandom_range(0, 15)), w});
      if (k == 3) hold_armed = 1'b1;
      run_ticks(110, (k == 6) ? ShapeNoise : ShapeJudge);
      drain_results();
    end

    // Raise warm-up past the tick count: summing resumes and the smoke alarm is held
    // at zero, while the baseline and the ready flag stay as they were.
    write_reg(CfgWarmup, 16'(int'(cond_model.ticks) + int'($urandom_range(5, 30))));
    write_reg(CfgOffset, 16'($urandom_range(1, 300)));
    run_ticks(int'(cond_model.warmup_len) - int'(cond_model.ticks) + 40, ShapeJudge);
    drain_results();

    // Zero warm-up with zero offset: every tick is judged, and every judged tick hits.
    write_reg(CfgWarmup, 16'd0);
    write_reg(CfgOffset, 16'd0);
    run_ticks(30, ShapeJudge);
    drain_results();

    // Longest warm-up: summing resumes with the smoke alarm held low; stream the ticks
    // back to back with the receiver always taking.
    write_reg(CfgOffset, 16'($urandom_range(0, 4095)));
    write_reg(CfgWarmup, 16'hFFFF);
    quick_mode = 1'b1;
    run_ticks(40, ShapeNoise);
    drain_results();
    quick_mode = 1'b0;
    write_reg(CfgFlameTh, 16'($urandom_range(0, 4095)));
    run_ticks(30, ShapeJudge);

    drain_results();
    repeat (TailCycles) @(posedge clk_i);
    cond_model.close_out();

    $display("tb_top: %0d results checked, %0d of them judged for smoke, baseline %0d",
             cond_model.checked, cond_model.judged_ticks, cond_model.baseline);
    $display("tb_top: smoke alarm high on %0d, flame alarm high on %0d, %0d register writes",
             cond_model.smoke_alarm_ticks, cond_model.flame_alarm_ticks,
             cond_model.reg_writes);
    if (cond_model.errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

// File: files.f
src/gfac_pkg.sv
src/gfac_in_if.sv
src/gfac_out_if.sv
src/gas_flame_alarm_conditioner_top.sv
dv/gfac_tb_pkg.sv
dv/tb_top.sv
